FILE: design/assert_macros.svh
// Assertion macros shared by the compositor RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compositor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compositor assertion failed");

// The condition must never be true.
`define GFC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("compositor assertion failed");

`endif

FILE: design/gfc_pkg.sv
// Shared types and constants of the GIF frame compositor.
// Used by the compositor top level and the bench; depends on nothing.
`default_nettype none

package gfc_pkg;

    // Default limits of the canvas and palette.
    localparam int MAX_CANVAS_WIDTH_DEF  = 256;
    localparam int MAX_CANVAS_HEIGHT_DEF = 256;
    localparam int PALETTE_ENTRIES_DEF   = 256;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

    // Configuration reset values.
    localparam logic [8:0]  CANVAS_WIDTH_RST  = 9'd256;
    localparam logic [8:0]  CANVAS_HEIGHT_RST = 9'd256;
    localparam logic [31:0] BACKGROUND_RST    = 32'd0;

    // Alpha byte of every painted pixel.
    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

    // Item operations.
    typedef enum logic [2:0] {
        OP_PALETTE = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_FRAME   = 3'd2,
        OP_PIXEL   = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    // Disposal methods.
    localparam logic [1:0] DISP_NONE       = 2'd0;
    localparam logic [1:0] DISP_KEEP       = 2'd1;
    localparam logic [1:0] DISP_BACKGROUND = 2'd2;
    localparam logic [1:0] DISP_PREVIOUS   = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPOSE,
        ST_DISPOSE_RUN,
        ST_SAVE,
        ST_SAVE_RUN,
        ST_CLEAR_RUN
    } state_t;

    // What a canvas sweep does at each address.
    typedef enum logic [1:0] {
        JOB_FILL_BG,
        JOB_FILL_ZERO,
        JOB_RESTORE,
        JOB_SAVE
    } job_t;

endpackage

`default_nettype wire

FILE: design/gfc_ram.sv
// Simple dual-port synchronous memory with one write and one registered read port.
// Used for the canvas, preserve and palette stores; no package dependency.
`default_nettype none

module gfc_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 32
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [DW-1:0]             wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output      logic [DW-1:0]             rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; a write to the same address in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/gfc_sweep.sv
// Raster address walker over a clipped canvas rectangle, one address a cycle.
// Used by the compositor top level for clears, disposal and save passes.
`default_nettype none

module gfc_sweep #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [$clog2(MAX_W)-1:0]           x0,
    input  wire logic [$clog2(MAX_W+1)-1:0]         x1,
    input  wire logic [$clog2(MAX_H)-1:0]           y0,
    input  wire logic [$clog2(MAX_H+1)-1:0]         y1,
    output      logic                               busy,
    output      logic [$clog2(MAX_W*MAX_H)-1:0]     addr
);

    localparam int XW  = $clog2(MAX_W);
    localparam int XW1 = $clog2(MAX_W + 1);
    localparam int YW  = $clog2(MAX_H);
    localparam int YW1 = $clog2(MAX_H + 1);
    localparam int AW  = $clog2(MAX_W * MAX_H);

    logic           busy_reg;
    logic [XW-1:0]  x_reg;
    logic [XW-1:0]  xs_reg;
    logic [XW1-1:0] xe_reg;
    logic [YW-1:0]  y_reg;
    logic [YW1-1:0] ye_reg;
    logic [AW-1:0]  base_reg;
    logic           row_end;
    logic           last_row;

    assign row_end  = (XW1'(x_reg) + XW1'(1)) == xe_reg;
    assign last_row = (YW1'(y_reg) + YW1'(1)) == ye_reg;

    // Control: the walker runs until the last address of the last row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && row_end && last_row)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Position counters; the row base steps by the canvas pitch.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x0;
            xs_reg   <= x0;
            xe_reg   <= x1;
            y_reg    <= y0;
            ye_reg   <= y1;
            base_reg <= AW'(AW'(y0) * AW'(MAX_W));
        end
        else if (busy_reg)
        begin
            if (row_end)
            begin
                x_reg    <= xs_reg;
                y_reg    <= y_reg + YW'(1);
                base_reg <= base_reg + AW'(MAX_W);
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    assign busy = busy_reg;
    assign addr = base_reg + AW'(x_reg);

endmodule

`default_nettype wire

FILE: design/gif_frame_compositor.sv
// GIF frame compositor top level: sequencer, frame state and the three stores.
// Depends on gfc_pkg, gfc_ram, gfc_sweep and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Palette, pixel and read items are taken one per cycle while the block is idle
// and no copy write is pending; a read result passes through rd_pend_reg and
// out_valid_reg, and a second read waits until the first result has been taken.
// A clear sweeps every pixel of the visible canvas (width times height, clipped
// to the maximum), and waits when it directly follows a painted pixel. A frame
// start steps through the dispose and save states, sweeping the disposal region
// (the old rectangle clipped to the canvas, or the whole visible canvas for a
// restore), then every visible pixel when the canvas is saved, then drains the
// last copy write of a save pass. These passes walk the canvas memory one word
// a cycle through its single write port. The stores need no clearing after reset.
module gif_frame_compositor #(
    parameter int MAX_CANVAS_WIDTH  = gfc_pkg::MAX_CANVAS_WIDTH_DEF,
    parameter int MAX_CANVAS_HEIGHT = gfc_pkg::MAX_CANVAS_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES   = gfc_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_enable,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic [7:0]         color_index,
    input  wire logic [23:0]        palette_rgb,
    input  wire logic [8:0]         palette_count,
    input  wire logic [15:0]        pos_x,
    input  wire logic [15:0]        pos_y,
    input  wire logic [15:0]        frame_width,
    input  wire logic [15:0]        frame_height,
    input  wire logic signed [8:0]  transparent_index,
    input  wire logic [1:0]         disposal_mode,
    input  wire logic               final_frame,
    input  wire logic               save_previous,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [31:0]        pixel_color
);

    localparam int XW  = $clog2(MAX_CANVAS_WIDTH);
    localparam int XW1 = $clog2(MAX_CANVAS_WIDTH + 1);
    localparam int YW  = $clog2(MAX_CANVAS_HEIGHT);
    localparam int YW1 = $clog2(MAX_CANVAS_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT);
    localparam int PW  = $clog2(PALETTE_ENTRIES);
    localparam int CW  = 17;

    // Configuration registers.
    logic [8:0]  canvas_width_reg;
    logic [8:0]  canvas_height_reg;
    logic [31:0] background_reg;

    // Sequencer.
    gfc_pkg::state_t state_reg;
    gfc_pkg::state_t state_next;
    gfc_pkg::job_t   job_reg;
    gfc_pkg::job_t   job_next;

    // Frame state.
    logic          preserve_valid_reg;
    logic          prev_valid_reg;
    logic [15:0]   prev_left_reg;
    logic [15:0]   prev_top_reg;
    logic [15:0]   prev_width_reg;
    logic [15:0]   prev_height_reg;
    logic [1:0]    prev_mode_reg;
    logic [15:0]   cur_left_reg;
    logic [15:0]   cur_top_reg;
    logic [15:0]   cur_width_reg;
    logic [15:0]   cur_height_reg;
    logic [8:0]    cur_tr_reg;
    logic [8:0]    cur_pcount_reg;
    logic          cur_draw_reg;
    logic [1:0]    cur_mode_reg;
    logic          save_req_reg;
    logic [15:0]   pix_col_reg;
    logic [15:0]   pix_row_reg;

    // Pipeline registers.
    logic          pix_wr_reg;
    logic [AW-1:0] pix_addr_reg;
    logic          rd_pend_reg;
    logic          rd_in_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic          cp_wr_reg;
    logic          cp_to_canvas_reg;
    logic [AW-1:0] cp_addr_reg;

    // Handshake and operation decode.
    logic accept;
    logic acc_palette;
    logic acc_clear;
    logic acc_frame;
    logic acc_pixel;
    logic acc_read;

    // Effective canvas size.
    logic [CW-1:0] eff_w;
    logic [CW-1:0] eff_h;

    // Sweep interface.
    logic           sw_start;
    logic [CW-1:0]  sw_x0;
    logic [CW-1:0]  sw_x1;
    logic [CW-1:0]  sw_y0;
    logic [CW-1:0]  sw_y1;
    logic           sw_busy;
    logic [AW-1:0]  sw_addr;

    // Disposal decision.
    logic          covered;
    logic          disp_fill;
    logic          disp_restore;
    logic [CW-1:0] old_x1;
    logic [CW-1:0] old_y1;
    logic          area_nonempty;
    logic          old_nonempty;

    // Pixel path.
    logic [CW-1:0] pix_x;
    logic [CW-1:0] pix_y;
    logic          pix_live;
    logic          pix_paint;
    logic [AW-1:0] pix_addr;
    logic          pix_last_col;

    // Read path.
    logic          rd_in;
    logic [AW-1:0] rd_addr;

    // Memory ports.
    logic          cv_we;
    logic [AW-1:0] cv_waddr;
    logic [31:0]   cv_wdata;
    logic          cv_re;
    logic [AW-1:0] cv_raddr;
    logic [31:0]   cv_rdata;
    logic          ps_we;
    logic          ps_re;
    logic [31:0]   ps_rdata;
    logic          pal_we;
    logic          pal_re;
    logic [23:0]   pal_rdata;

    // Effective canvas size saturates at the maximum.
    always_comb
    begin
        eff_w = (CW'(canvas_width_reg) > CW'(MAX_CANVAS_WIDTH))
                ? CW'(MAX_CANVAS_WIDTH) : CW'(canvas_width_reg);
        eff_h = (CW'(canvas_height_reg) > CW'(MAX_CANVAS_HEIGHT))
                ? CW'(MAX_CANVAS_HEIGHT) : CW'(canvas_height_reg);
    end

    // Items are taken only when idle; a read also needs a free result slot,
    // and a clear waits for a pixel write that is still in flight.
    assign in_ready = (state_reg == gfc_pkg::ST_IDLE) && !cp_wr_reg
                      && !((operation == gfc_pkg::OP_READ) && (rd_pend_reg || out_valid_reg))
                      && !((operation == gfc_pkg::OP_CLEAR) && pix_wr_reg);
    assign accept      = in_valid && in_ready;
    assign acc_palette = accept && (operation == gfc_pkg::OP_PALETTE);
    assign acc_clear   = accept && (operation == gfc_pkg::OP_CLEAR);
    assign acc_frame   = accept && (operation == gfc_pkg::OP_FRAME);
    assign acc_pixel   = accept && (operation == gfc_pkg::OP_PIXEL);
    assign acc_read    = accept && (operation == gfc_pkg::OP_READ);

    // Disposal is skipped when an opaque new frame covers the old rectangle.
    always_comb
    begin
        covered = cur_tr_reg[8]
                  && (cur_left_reg <= prev_left_reg)
                  && ((CW'(prev_left_reg) + CW'(prev_width_reg))
                      <= (CW'(cur_left_reg) + CW'(cur_width_reg)))
                  && (cur_top_reg <= prev_top_reg)
                  && ((CW'(prev_top_reg) + CW'(prev_height_reg))
                      <= (CW'(cur_top_reg) + CW'(cur_height_reg)));
        disp_fill    = prev_valid_reg && !covered
                       && (prev_mode_reg == gfc_pkg::DISP_BACKGROUND);
        disp_restore = prev_valid_reg && !covered && preserve_valid_reg
                       && (prev_mode_reg == gfc_pkg::DISP_PREVIOUS);
        old_x1 = CW'(prev_left_reg) + CW'(prev_width_reg);
        old_y1 = CW'(prev_top_reg) + CW'(prev_height_reg);
        if (old_x1 > eff_w)
        begin
            old_x1 = eff_w;
        end
        if (old_y1 > eff_h)
        begin
            old_y1 = eff_h;
        end
        old_nonempty  = (CW'(prev_left_reg) < old_x1) && (CW'(prev_top_reg) < old_y1);
        area_nonempty = (eff_w != '0) && (eff_h != '0);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gfc_pkg::ST_IDLE:
            begin
                if (acc_clear)
                begin
                    state_next = gfc_pkg::ST_CLEAR_RUN;
                end
                else if (acc_frame)
                begin
                    state_next = gfc_pkg::ST_DISPOSE;
                end
            end
            gfc_pkg::ST_DISPOSE:
            begin
                if ((disp_fill && old_nonempty) || (disp_restore && area_nonempty))
                begin
                    state_next = gfc_pkg::ST_DISPOSE_RUN;
                end
                else
                begin
                    state_next = gfc_pkg::ST_SAVE;
                end
            end
            gfc_pkg::ST_DISPOSE_RUN:
            begin
                if (!sw_busy)
                begin
                    state_next = gfc_pkg::ST_SAVE;
                end
            end
            gfc_pkg::ST_SAVE:
            begin
                if (save_req_reg && area_nonempty)
                begin
                    state_next = gfc_pkg::ST_SAVE_RUN;
                end
                else
                begin
                    state_next = gfc_pkg::ST_IDLE;
                end
            end
            gfc_pkg::ST_SAVE_RUN, gfc_pkg::ST_CLEAR_RUN:
            begin
                if (!sw_busy)
                begin
                    state_next = gfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sweep launch and bounds for each state.
    always_comb
    begin
        sw_start = 1'b0;
        sw_x0    = '0;
        sw_x1    = eff_w;
        sw_y0    = '0;
        sw_y1    = eff_h;
        job_next = job_reg;
        case (state_reg)
            gfc_pkg::ST_IDLE:
            begin
                if (acc_clear && area_nonempty)
                begin
                    sw_start = 1'b1;
                    job_next = gfc_pkg::JOB_FILL_BG;
                end
            end
            gfc_pkg::ST_DISPOSE:
            begin
                if (disp_fill && old_nonempty)
                begin
                    sw_start = 1'b1;
                    sw_x0    = CW'(prev_left_reg);
                    sw_x1    = old_x1;
                    sw_y0    = CW'(prev_top_reg);
                    sw_y1    = old_y1;
                    job_next = gfc_pkg::JOB_FILL_ZERO;
                end
                else if (disp_restore && area_nonempty)
                begin
                    sw_start = 1'b1;
                    job_next = gfc_pkg::JOB_RESTORE;
                end
            end
            gfc_pkg::ST_SAVE:
            begin
                if (save_req_reg && area_nonempty)
                begin
                    sw_start = 1'b1;
                    job_next = gfc_pkg::JOB_SAVE;
                end
            end
            default:
            begin
                sw_start = 1'b0;
            end
        endcase
    end

    // Pixel placement and drop tests.
    always_comb
    begin
        pix_x    = CW'(cur_left_reg) + CW'(pix_col_reg);
        pix_y    = CW'(cur_top_reg) + CW'(pix_row_reg);
        pix_live = (cur_width_reg != '0) && (pix_row_reg < cur_height_reg);
        pix_paint = pix_live && cur_draw_reg && (pix_x < eff_w) && (pix_y < eff_h)
                    && !(!cur_tr_reg[8] && (cur_tr_reg[7:0] == color_index))
                    && (9'(color_index) < cur_pcount_reg)
                    && (9'(color_index) < 9'(PALETTE_ENTRIES));
        pix_addr = AW'(AW'(pix_y[YW-1:0]) * AW'(MAX_CANVAS_WIDTH)) + AW'(pix_x[XW-1:0]);
        pix_last_col = (CW'(pix_col_reg) + CW'(1)) >= CW'(cur_width_reg);
    end

    // Read coordinate.
    always_comb
    begin
        rd_in   = (CW'(pos_x) < eff_w) && (CW'(pos_y) < eff_h);
        rd_addr = AW'(AW'(pos_y[YW-1:0]) * AW'(MAX_CANVAS_WIDTH)) + AW'(pos_x[XW-1:0]);
    end

    // Canvas and preserve port selection; the users never overlap in time.
    always_comb
    begin
        cv_we    = 1'b0;
        cv_waddr = sw_addr;
        cv_wdata = '0;
        ps_we    = 1'b0;
        if (pix_wr_reg)
        begin
            cv_we    = 1'b1;
            cv_waddr = pix_addr_reg;
            cv_wdata = {gfc_pkg::OPAQUE_ALPHA, pal_rdata};
        end
        else if (cp_wr_reg && cp_to_canvas_reg)
        begin
            cv_we    = 1'b1;
            cv_waddr = cp_addr_reg;
            cv_wdata = ps_rdata;
        end
        else if (sw_busy && (job_reg == gfc_pkg::JOB_FILL_BG))
        begin
            cv_we    = 1'b1;
            cv_wdata = background_reg;
        end
        else if (sw_busy && (job_reg == gfc_pkg::JOB_FILL_ZERO))
        begin
            cv_we    = 1'b1;
        end
        ps_we    = cp_wr_reg && !cp_to_canvas_reg;
        cv_re    = acc_read || (sw_busy && (job_reg == gfc_pkg::JOB_SAVE));
        cv_raddr = acc_read ? rd_addr : sw_addr;
        ps_re    = sw_busy && (job_reg == gfc_pkg::JOB_RESTORE);
        pal_we   = acc_palette && (9'(color_index) < 9'(PALETTE_ENTRIES));
        pal_re   = acc_pixel;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= gfc_pkg::CANVAS_WIDTH_RST;
            canvas_height_reg <= gfc_pkg::CANVAS_HEIGHT_RST;
            background_reg    <= gfc_pkg::BACKGROUND_RST;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                gfc_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[8:0];
                gfc_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[8:0];
                gfc_pkg::CFG_BACKGROUND:    background_reg    <= cfg_data;
                default:                    background_reg    <= background_reg;
            endcase
        end
    end

    // Sequencer and frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= gfc_pkg::ST_IDLE;
            job_reg            <= gfc_pkg::JOB_FILL_BG;
            preserve_valid_reg <= 1'b0;
            prev_valid_reg     <= 1'b0;
            prev_left_reg      <= '0;
            prev_top_reg       <= '0;
            prev_width_reg     <= '0;
            prev_height_reg    <= '0;
            prev_mode_reg      <= gfc_pkg::DISP_NONE;
            cur_left_reg       <= '0;
            cur_top_reg        <= '0;
            cur_width_reg      <= '0;
            cur_height_reg     <= '0;
            cur_tr_reg         <= '0;
            cur_pcount_reg     <= '0;
            cur_draw_reg       <= 1'b0;
            cur_mode_reg       <= gfc_pkg::DISP_NONE;
            save_req_reg       <= 1'b0;
            pix_col_reg        <= '0;
            pix_row_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if (acc_clear)
            begin
                prev_valid_reg <= 1'b0;
            end
            // New frame description is held until the old one is disposed.
            if (acc_frame)
            begin
                cur_left_reg   <= pos_x;
                cur_top_reg    <= pos_y;
                cur_width_reg  <= frame_width;
                cur_height_reg <= frame_height;
                cur_tr_reg     <= transparent_index;
                cur_pcount_reg <= palette_count;
                cur_mode_reg   <= disposal_mode;
                cur_draw_reg   <= final_frame
                                  || !((disposal_mode == gfc_pkg::DISP_BACKGROUND)
                                       || (disposal_mode == gfc_pkg::DISP_PREVIOUS));
                save_req_reg   <= save_previous;
                pix_col_reg    <= '0;
                pix_row_reg    <= '0;
            end
            // Once the disposal is decided the new frame becomes the previous one.
            if (state_reg == gfc_pkg::ST_DISPOSE)
            begin
                prev_left_reg   <= cur_left_reg;
                prev_top_reg    <= cur_top_reg;
                prev_width_reg  <= cur_width_reg;
                prev_height_reg <= cur_height_reg;
                prev_mode_reg   <= cur_mode_reg;
                prev_valid_reg  <= 1'b1;
            end
            if ((state_reg == gfc_pkg::ST_SAVE) && save_req_reg)
            begin
                preserve_valid_reg <= 1'b1;
            end
            // Raster position advances for every pixel of a live frame.
            if (acc_pixel && pix_live)
            begin
                if (pix_last_col)
                begin
                    pix_col_reg <= '0;
                    pix_row_reg <= pix_row_reg + 16'd1;
                end
                else
                begin
                    pix_col_reg <= pix_col_reg + 16'd1;
                end
            end
        end
    end

    // Pixel write, copy write-behind and read result pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_wr_reg    <= 1'b0;
            cp_wr_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_wr_reg  <= acc_pixel && pix_paint;
            cp_wr_reg   <= sw_busy && ((job_reg == gfc_pkg::JOB_RESTORE)
                                       || (job_reg == gfc_pkg::JOB_SAVE));
            rd_pend_reg <= acc_read;
            if (rd_pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        pix_addr_reg     <= pix_addr;
        cp_addr_reg      <= sw_addr;
        cp_to_canvas_reg <= (job_reg == gfc_pkg::JOB_RESTORE);
        if (acc_read)
        begin
            rd_in_reg <= rd_in;
        end
        if (rd_pend_reg)
        begin
            out_data_reg <= rd_in_reg ? cv_rdata : 32'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = out_data_reg;

    gfc_sweep #(
        .MAX_W (MAX_CANVAS_WIDTH),
        .MAX_H (MAX_CANVAS_HEIGHT)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sw_start),
        .x0    (sw_x0[XW-1:0]),
        .x1    (sw_x1[XW1-1:0]),
        .y0    (sw_y0[YW-1:0]),
        .y1    (sw_y1[YW1-1:0]),
        .busy  (sw_busy),
        .addr  (sw_addr)
    );

    gfc_ram #(
        .DEPTH (MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT),
        .DW    (32)
    ) u_canvas (
        .clk   (clk),
        .we    (cv_we),
        .waddr (cv_waddr),
        .wdata (cv_wdata),
        .re    (cv_re),
        .raddr (cv_raddr),
        .rdata (cv_rdata)
    );

    gfc_ram #(
        .DEPTH (MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT),
        .DW    (32)
    ) u_preserve (
        .clk   (clk),
        .we    (ps_we),
        .waddr (cp_addr_reg),
        .wdata (cv_rdata),
        .re    (ps_re),
        .raddr (sw_addr),
        .rdata (ps_rdata)
    );

    gfc_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .DW    (24)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (color_index[PW-1:0]),
        .wdata (palette_rgb),
        .re    (pal_re),
        .raddr (color_index[PW-1:0]),
        .rdata (pal_rdata)
    );

    // A pixel write never collides with a sweep or copy write.
    `GFC_ASSERT_NEVER(a_single_canvas_writer, pix_wr_reg && (sw_busy || cp_wr_reg))
    // A read in flight always produces a result beat next cycle.
    `GFC_ASSERT_NEXT(a_read_result, rd_pend_reg, out_valid_reg)
    // The walker only runs in a state that consumes its addresses.
    `GFC_ASSERT_IMP(a_sweep_owned, sw_busy,
        (state_reg == gfc_pkg::ST_DISPOSE_RUN) || (state_reg == gfc_pkg::ST_SAVE_RUN)
        || (state_reg == gfc_pkg::ST_CLEAR_RUN) || (state_reg == gfc_pkg::ST_SAVE))
    // Items are never taken while canvas passes are outstanding.
    `GFC_ASSERT_IMP(a_ready_quiet, in_ready, !sw_busy && !cp_wr_reg)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the GIF frame compositor: directed cases, then random phases.
// Depends on gfc_pkg and gif_frame_compositor; holds its own canvas predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int CANVAS_SIDE = 256;
    localparam int CYCLE_LIMIT = 20000000;

    // One input beat, field by field.
    typedef struct {
        logic [2:0]        op;
        logic [7:0]        cidx;
        logic [23:0]       rgb;
        logic [8:0]        pcount;
        logic [15:0]       px;
        logic [15:0]       py;
        logic [15:0]       fw;
        logic [15:0]       fh;
        logic signed [8:0] trans;
        logic [1:0]        disp;
        logic              fin;
        logic              save;
    } beat_t;

    // Canvas predictor and the queue of read results still owed by the block.
    class pixel_scoreboard;
        bit [31:0] canvas_mem [CANVAS_SIDE*CANVAS_SIDE];
        bit [31:0] keep_mem [CANVAS_SIDE*CANVAS_SIDE];
        bit [23:0] palette_mem [256];
        int  canvas_w, canvas_h;
        bit [31:0] bg_color;
        bit  keep_ok, old_valid;
        int  old_l, old_t, old_w, old_h;
        bit [1:0] old_disp;
        int  cur_l, cur_t, cur_w, cur_h, cur_trans, cur_pcount;
        bit  cur_draw;
        int  column, row;
        bit [31:0] owed_colors [$];
        int  errors;

        function new();
            canvas_w = gfc_pkg::CANVAS_WIDTH_RST;
            canvas_h = gfc_pkg::CANVAS_HEIGHT_RST;
            bg_color = gfc_pkg::BACKGROUND_RST;
        endfunction

        function int vis_w();
            return canvas_w > CANVAS_SIDE ? CANVAS_SIDE : canvas_w;
        endfunction

        function int vis_h();
            return canvas_h > CANVAS_SIDE ? CANVAS_SIDE : canvas_h;
        endfunction

        function void configure(logic [1:0] idx, logic [31:0] data);
            if (idx == gfc_pkg::CFG_CANVAS_WIDTH) canvas_w = data[8:0];
            else if (idx == gfc_pkg::CFG_CANVAS_HEIGHT) canvas_h = data[8:0];
            else if (idx == gfc_pkg::CFG_BACKGROUND) bg_color = data;
        endfunction

        function void fill_rect(int l, int t, int w, int h, bit [31:0] color);
            int xe, ye;
            xe = l + w;
            ye = t + h;
            if (xe > vis_w()) xe = vis_w();
            if (ye > vis_h()) ye = vis_h();
            for (int y = t; y < ye; y++)
                for (int x = l; x < xe; x++)
                    canvas_mem[y*CANVAS_SIDE + x] = color;
        endfunction

        // Frame start: dispose the old frame, optionally save, then latch the new one.
        function void start_frame(beat_t b);
            int  l, t, w, h, tr;
            bit  covered;
            l = b.px; t = b.py; w = b.fw; h = b.fh;
            tr = b.trans;
            if (old_valid && (old_disp == gfc_pkg::DISP_BACKGROUND
                              || old_disp == gfc_pkg::DISP_PREVIOUS))
            begin
                covered = tr < 0 && l <= old_l && old_l + old_w <= l + w
                          && t <= old_t && old_t + old_h <= t + h;
                if (!covered)
                begin
                    if (old_disp == gfc_pkg::DISP_BACKGROUND)
                        fill_rect(old_l, old_t, old_w, old_h, 32'd0);
                    else if (keep_ok)
                        for (int y = 0; y < vis_h(); y++)
                            for (int x = 0; x < vis_w(); x++)
                                canvas_mem[y*CANVAS_SIDE + x] = keep_mem[y*CANVAS_SIDE + x];
                end
            end
            if (b.save)
            begin
                for (int y = 0; y < vis_h(); y++)
                    for (int x = 0; x < vis_w(); x++)
                        keep_mem[y*CANVAS_SIDE + x] = canvas_mem[y*CANVAS_SIDE + x];
                keep_ok = 1;
            end
            old_l = l; old_t = t; old_w = w; old_h = h;
            old_disp = b.disp;
            old_valid = 1;
            cur_l = l; cur_t = t; cur_w = w; cur_h = h;
            cur_trans = tr;
            cur_pcount = b.pcount;
            cur_draw = b.fin || !(b.disp == gfc_pkg::DISP_BACKGROUND
                                  || b.disp == gfc_pkg::DISP_PREVIOUS);
            column = 0;
            row = 0;
        endfunction

        function void put_pixel(int idx);
            int x, y;
            if (cur_w == 0 || row >= cur_h) return;
            x = cur_l + column;
            y = cur_t + row;
            if (cur_draw && x < vis_w() && y < vis_h() && idx != cur_trans
                && idx < cur_pcount && idx < 256)
                canvas_mem[y*CANVAS_SIDE + x] = {gfc_pkg::OPAQUE_ALPHA, palette_mem[idx]};
            column++;
            if (column >= cur_w)
            begin
                column = 0;
                row++;
            end
        endfunction

        // Called once per accepted input beat.
        function void note_beat(beat_t b);
            int x, y;
            case (b.op)
                gfc_pkg::OP_PALETTE: palette_mem[b.cidx] = b.rgb;
                gfc_pkg::OP_CLEAR:
                begin
                    fill_rect(0, 0, CANVAS_SIDE, CANVAS_SIDE, bg_color);
                    old_valid = 0;
                end
                gfc_pkg::OP_FRAME: start_frame(b);
                gfc_pkg::OP_PIXEL: put_pixel(b.cidx);
                gfc_pkg::OP_READ:
                begin
                    x = b.px;
                    y = b.py;
                    owed_colors.push_back((x < vis_w() && y < vis_h())
                                          ? canvas_mem[y*CANVAS_SIDE + x] : 32'd0);
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // Called once per accepted result beat.
        task check_color(logic [31:0] got);
            bit [31:0] want;
            if (owed_colors.size() == 0)
                report($sformatf("unexpected result beat %08h", got));
            else
            begin
                want = owed_colors.pop_front();
                if (got !== want)
                    report($sformatf("pixel_color %08h, predicted %08h", got, want));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write_enable;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        operation;
    logic [7:0]        color_index;
    logic [23:0]       palette_rgb;
    logic [8:0]        palette_count;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [15:0]       frame_width;
    logic [15:0]       frame_height;
    logic signed [8:0] transparent_index;
    logic [1:0]        disposal_mode;
    logic              final_frame;
    logic              save_previous;
    logic              out_valid;
    logic              out_ready;
    logic [31:0]       pixel_color;

    pixel_scoreboard sb;
    int  cycles;
    int  burst_left;
    bit  gaps_on;
    logic [7:0] ready_pattern;
    int  ready_phase;

    gif_frame_compositor dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .color_index(color_index), .palette_rgb(palette_rgb),
        .palette_count(palette_count), .pos_x(pos_x), .pos_y(pos_y),
        .frame_width(frame_width), .frame_height(frame_height),
        .transparent_index(transparent_index), .disposal_mode(disposal_mode),
        .final_frame(final_frame), .save_previous(save_previous),
        .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Cycle counter with a hard limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: the ready line follows a rotating stall pattern that is renewed now and then.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_color(pixel_color);
        ready_phase <= ready_phase + 1;
        if (ready_phase % 97 == 0)
        begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
        end
        out_ready <= ready_pattern[ready_phase % 8];
    end

    function beat_t blank_beat(logic [2:0] op);
        beat_t b;
        b.op = op; b.cidx = 0; b.rgb = 0; b.pcount = 0; b.px = 0; b.py = 0;
        b.fw = 0; b.fh = 0; b.trans = -1; b.disp = gfc_pkg::DISP_NONE; b.fin = 0; b.save = 0;
        return b;
    endfunction

    function beat_t frame_beat(int l, int t, int w, int h, int tr, logic [1:0] disp,
                               bit fin, bit save, int pcount);
        beat_t b;
        b = blank_beat(gfc_pkg::OP_FRAME);
        b.px = l; b.py = t; b.fw = w; b.fh = h; b.trans = tr;
        b.disp = disp; b.fin = fin; b.save = save; b.pcount = pcount;
        return b;
    endfunction

    function beat_t pixel_beat(int idx);
        beat_t b;
        b = blank_beat(gfc_pkg::OP_PIXEL);
        b.cidx = idx;
        return b;
    endfunction

    function beat_t read_beat(int x, int y);
        beat_t b;
        b = blank_beat(gfc_pkg::OP_READ);
        b.px = x; b.py = y;
        return b;
    endfunction

    // Drive one beat and hold it until accepted; with gaps_on, bursts are broken by random gaps.
    task send_beat(beat_t b);
        if (gaps_on && burst_left <= 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid          <= 1;
        operation         <= b.op;
        color_index       <= b.cidx;
        palette_rgb       <= b.rgb;
        palette_count     <= b.pcount;
        pos_x             <= b.px;
        pos_y             <= b.py;
        frame_width       <= b.fw;
        frame_height      <= b.fh;
        transparent_index <= b.trans;
        disposal_mode     <= b.disp;
        final_frame       <= b.fin;
        save_previous     <= b.save;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(b);
        burst_left--;
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_write_enable <= 1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge clk);
        cfg_write_enable <= 0;
        sb.configure(idx, data);
    endtask

    // A closing read returns only once every earlier beat has been worked through.
    task drain_block();
        send_beat(read_beat(0, 0));
        in_valid <= 0;
        while (sb.owed_colors.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // New canvas setting: clear, then save so the preserve store covers the visible canvas.
    task start_phase(int w, int h, logic [31:0] bg);
        write_reg(gfc_pkg::CFG_CANVAS_WIDTH, w);
        write_reg(gfc_pkg::CFG_CANVAS_HEIGHT, h);
        write_reg(gfc_pkg::CFG_BACKGROUND, bg);
        send_beat(blank_beat(gfc_pkg::OP_CLEAR));
        send_beat(frame_beat(0, 0, 0, 0, -1, gfc_pkg::DISP_KEEP, 0, 1, 256));
    endtask

    function int coord(int span);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        return $urandom_range(0, span);
    endfunction

    // Random traffic for one phase: mostly whole frames with pixel streams and read-backs.
    task random_phase(int beats, bit wide_canvas);
        beat_t b;
        int  sent, span, n, w, h, sel, nr;
        span = wide_canvas ? 12 : sb.vis_w() + 2;
        sent = 0;
        while (sent < beats)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span);
                h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span);
                b = frame_beat(wide_canvas ? $urandom_range(0, 300) : coord(span),
                               wide_canvas ? $urandom_range(0, 300) : coord(span), w, h,
                               $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 511) - 256,
                               wide_canvas ? $urandom_range(0, 2) : $urandom_range(0, 3),
                               $urandom_range(0, 1),
                               wide_canvas ? ($urandom_range(0, 9) == 0)
                                           : ($urandom_range(0, 3) == 0),
                               $urandom_range(0, 2) == 0 ? 256 : $urandom_range(0, 256));
                send_beat(b);
                n = (longint'(w) * longint'(h) <= 80) ? w * h : $urandom_range(1, 40);
                n += $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    send_beat(pixel_beat($urandom_range(0, 255)));
                nr = $urandom_range(1, 3);
                repeat (nr)
                    send_beat(read_beat(coord(sb.vis_w()), coord(sb.vis_h())));
                sent += n + 1 + nr;
            end
            else
            begin
                if (sel < 75)
                    b = read_beat(coord(sb.vis_w()), coord(sb.vis_h()));
                else if (sel < 85)
                begin
                    b = blank_beat(gfc_pkg::OP_PALETTE);
                    b.cidx = $urandom_range(0, 255);
                    b.rgb = $urandom_range(0, 24'hffffff);
                end
                else if (sel < 88 && !wide_canvas)
                    b = blank_beat(gfc_pkg::OP_CLEAR);
                else if (sel < 93)
                begin
                    b = blank_beat(3'($urandom_range(5, 7)));
                    b.cidx = $urandom_range(0, 255);
                end
                else
                    b = pixel_beat($urandom_range(0, 255));
                send_beat(b);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        beat_t b;
        int    w, h;
        sb = new();
        cycles = 0;
        burst_left = 0;
        gaps_on = 0;
        ready_pattern = 8'hff;
        ready_phase = 0;
        rst_n <= 0;
        cfg_write_enable <= 0; cfg_index <= 0; cfg_data <= 0;
        in_valid <= 0; operation <= 0; color_index <= 0; palette_rgb <= 0;
        palette_count <= 0; pos_x <= 0; pos_y <= 0; frame_width <= 0; frame_height <= 0;
        transparent_index <= 0; disposal_mode <= 0; final_frame <= 0; save_previous <= 0;
        out_ready <= 1;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Load every palette entry and the whole canvas once, so no store is read unwritten.
        for (int i = 0; i < 256; i++)
        begin
            b = blank_beat(gfc_pkg::OP_PALETTE);
            b.cidx = i;
            b.rgb = (i == 0) ? 24'h000000 : (i == 255) ? 24'hffffff : $urandom_range(0, 24'hffffff);
            send_beat(b);
        end
        send_beat(blank_beat(gfc_pkg::OP_CLEAR));

        // Directed: a restore with nothing saved, and an undrawn frame partly off canvas.
        send_beat(frame_beat(250, 250, 10, 10, 5, gfc_pkg::DISP_PREVIOUS, 0, 0, 256));
        send_beat(pixel_beat(1));
        send_beat(pixel_beat(2));
        // Background disposal frame, drawn because it is final, with a save.
        send_beat(frame_beat(0, 0, 4, 2, -1, gfc_pkg::DISP_BACKGROUND, 1, 1, 256));
        send_beat(pixel_beat(0));
        send_beat(pixel_beat(255));
        send_beat(pixel_beat(5));
        for (int i = 0; i < 6; i++) send_beat(pixel_beat(i + 7));
        send_beat(read_beat(0, 0));
        send_beat(read_beat(3, 1));
        send_beat(read_beat(65535, 65535));
        // An opaque frame covering the old one skips disposal; indices past the count drop.
        send_beat(frame_beat(0, 0, 8, 8, -1, gfc_pkg::DISP_PREVIOUS, 1, 0, 4));
        send_beat(pixel_beat(3));
        send_beat(pixel_beat(4));
        send_beat(pixel_beat(200));
        // A transparent frame forces the saved copy back.
        send_beat(frame_beat(0, 0, 1, 1, 0, gfc_pkg::DISP_NONE, 0, 0, 256));
        send_beat(pixel_beat(0));
        send_beat(read_beat(1, 0));
        send_beat(blank_beat(3'd5));
        send_beat(blank_beat(3'd7));
        drain_block();

        // Extremes of the canvas registers: saturated, empty, one-pixel, one-row and one-column canvases.
        gaps_on = 1;
        start_phase(511, 300, 32'hffffffff);
        random_phase(20, 1);
        drain_block();
        start_phase(0, 5, 32'h12345678);
        random_phase(40, 0);
        drain_block();
        start_phase(5, 0, 32'h0);
        random_phase(40, 0);
        drain_block();
        start_phase(1, 1, 32'h80808080);
        random_phase(60, 0);
        drain_block();
        start_phase(256, 1, 32'h7f7f7f7f);
        random_phase(60, 0);
        drain_block();
        start_phase(1, 256, 32'hdeadbeef);
        random_phase(60, 0);
        drain_block();

        // Random small canvases, some without any sender gaps.
        for (int p = 0; p < 10; p++)
        begin
            gaps_on = $urandom_range(0, 3) != 0;
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
            start_phase(w, h, $urandom());
            random_phase(110, 0);
            drain_block();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.owed_colors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
